@@ design/rpct_pkg.sv @@
// Shared types, codes and constants of the RGB pixel color transform.
package rpct_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int MODE_W          = 3;
    localparam int CHSEL_W         = 2;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int IN_DATA_W       = 48;
    localparam int OUT_DATA_W      = 72;
    localparam int WEIGHT_W        = 10;
    localparam int SEPIA_SCALE     = 1000;

    // Transform modes.
    localparam logic [MODE_W-1:0] MODE_BITMAP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ISOLATE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEPIA   = 3'd4;

    // Channel selections.
    localparam logic [CHSEL_W-1:0] CH_RED   = 2'd0;
    localparam logic [CHSEL_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CHSEL_W-1:0] CH_BLUE  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IN_MAX   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRAY_MAX = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHSEL    = 2'd3;

    localparam logic [MODE_W-1:0]     MODE_RESET     = MODE_BITMAP;
    localparam logic [FIELD_W-1:0]    IN_MAX_RESET   = 16'd255;
    localparam logic [FIELD_W-1:0]    GRAY_MAX_RESET = 16'd255;
    localparam logic [CHSEL_W-1:0]    CHSEL_RESET    = CH_RED;

    // Sepia weights in thousandths, [output channel][input channel].
    localparam logic [WEIGHT_W-1:0] SEPIA_WEIGHT [3][3] = '{
        '{10'd393, 10'd769, 10'd189},
        '{10'd349, 10'd686, 10'd168},
        '{10'd272, 10'd534, 10'd131}
    };

    // Per-word control that rides along the pipeline.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              black;
        logic              gray_sat;
    } rpct_ctrl_t;

endpackage

@@ design/rpct_cfg_regs.sv @@
// Configuration register file of the pixel color transform.
module rpct_cfg_regs
    import rpct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [MODE_W-1:0]      mode,
    output logic [FIELD_W-1:0]     in_max,
    output logic [FIELD_W-1:0]     gray_max,
    output logic [CHSEL_W-1:0]     chsel
);

    logic [MODE_W-1:0]  mode_reg;
    logic [FIELD_W-1:0] in_max_reg;
    logic [FIELD_W-1:0] gray_max_reg;
    logic [CHSEL_W-1:0] chsel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RESET;
            in_max_reg   <= IN_MAX_RESET;
            gray_max_reg <= GRAY_MAX_RESET;
            chsel_reg    <= CHSEL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:     mode_reg     <= cfg_data[MODE_W-1:0];
                CFG_IN_MAX:   in_max_reg   <= cfg_data[FIELD_W-1:0];
                CFG_GRAY_MAX: gray_max_reg <= cfg_data[FIELD_W-1:0];
                CFG_CHSEL:    chsel_reg    <= cfg_data[CHSEL_W-1:0];
                default:      ;
            endcase
        end
    end

    assign mode     = mode_reg;
    assign in_max   = in_max_reg;
    assign gray_max = gray_max_reg;
    assign chsel    = chsel_reg;

endmodule

@@ design/rpct_front.sv @@
// Four front stages: channel sums and selects, products, sepia scaling and clamping.
module rpct_front
    import rpct_pkg::*;
#(
    parameter int SB = SAMPLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] red_in,
    input  logic [FIELD_W-1:0] green_in,
    input  logic [FIELD_W-1:0] blue_in,
    input  logic [MODE_W-1:0]  mode,
    input  logic [FIELD_W-1:0] in_max,
    input  logic [FIELD_W-1:0] gray_max,
    input  logic [CHSEL_W-1:0] chsel,
    output logic               out_valid,
    input  logic               out_ready,
    output rpct_ctrl_t         ctrl,
    output logic [SB-1:0]      red,
    output logic [SB-1:0]      green,
    output logic [SB-1:0]      blue,
    output logic [SB-1:0]      gm,
    output logic [SB+1:0]      divisor,
    output logic [2*SB+1:0]    num
);

    localparam int SUM_W   = SB + 2;
    localparam int CMP_W   = SUM_W + 1;
    localparam int NUM_W   = 2 * SB + 2;
    localparam int PROD_W  = SB + WEIGHT_W;
    localparam int SEP_W   = SB + 11;
    // Exact floor(x / 1000) for x below 2**SEP_W: (x * RECIP) >> RECIP_SHIFT.
    localparam int RECIP_SHIFT = SEP_W + 10;
    localparam int RECIP_W     = SEP_W + 1;
    localparam int MUL_W       = SEP_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(SEPIA_SCALE) - 64'd1) / 64'(SEPIA_SCALE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // Stage 1 logic.
    logic [SB-1:0]     samp [3];
    logic [SB-1:0]     mx_in;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  div_next;
    logic [SB-1:0]     pass_next [3];
    rpct_ctrl_t        ctrl_next;

    always_comb
    begin
        samp[0]  = red_in[SB-1:0];
        samp[1]  = green_in[SB-1:0];
        samp[2]  = blue_in[SB-1:0];
        mx_in    = in_max[SB-1:0];
        sum_next = SUM_W'(samp[0]) + SUM_W'(samp[1]) + SUM_W'(samp[2]);
        div_next = SUM_W'(mx_in) + (SUM_W'(mx_in) << 1);

        ctrl_next.mode     = mode;
        ctrl_next.black    = (CMP_W'(sum_next) << 1) < CMP_W'(div_next);
        // A sum at or above three times the maximum pins the gray level at its top.
        ctrl_next.gray_sat = sum_next >= div_next;

        case (mode)
            MODE_ISOLATE:
            begin
                pass_next[0] = (chsel == CH_RED)   ? samp[0] : '0;
                pass_next[1] = (chsel == CH_GREEN) ? samp[1] : '0;
                pass_next[2] = (chsel == CH_BLUE)  ? samp[2] : '0;
            end
            MODE_REMOVE:
            begin
                pass_next[0] = (chsel == CH_RED)   ? '0 : samp[0];
                pass_next[1] = (chsel == CH_GREEN) ? '0 : samp[1];
                pass_next[2] = (chsel == CH_BLUE)  ? '0 : samp[2];
            end
            default:
            begin
                pass_next[0] = '0;
                pass_next[1] = '0;
                pass_next[2] = '0;
            end
        endcase
    end

    rpct_ctrl_t         ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg;
    logic [SUM_W-1:0]   sum1_reg;
    logic [SUM_W-1:0]   div1_reg, div2_reg, div3_reg, div4_reg;
    logic [SB-1:0]      gm1_reg, gm2_reg, gm3_reg, gm4_reg;
    logic [SB-1:0]      mx1_reg, mx2_reg, mx3_reg;
    logic [SB-1:0]      pass1_reg [3];
    logic [SB-1:0]      pass2_reg [3];
    logic [SB-1:0]      pass3_reg [3];
    logic [SB-1:0]      rgb4_reg  [3];
    logic [PROD_W-1:0]  prod1_reg [3][3];
    logic [SEP_W-1:0]   sep2_reg  [3];
    logic [MUL_W-1:0]   mul3_reg  [3];
    logic [NUM_W-1:0]   num2_reg, num3_reg, num4_reg;

    // Stage 4: sepia scaled by 1/1000, clamped to the maximum; other modes pass.
    logic [SB:0]        sep_q     [3];
    logic [SB-1:0]      rgb4_next [3];

    always_comb
    begin
        for (int o = 0; o < 3; o++)
        begin
            sep_q[o] = mul3_reg[o][RECIP_SHIFT +: SB+1];
            if (sep_q[o] > {1'b0, mx3_reg})
                rgb4_next[o] = mx3_reg;
            else
                rgb4_next[o] = sep_q[o][SB-1:0];
            if (ctrl3_reg.mode != MODE_SEPIA)
                rgb4_next[o] = pass3_reg[o];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ctrl1_reg <= ctrl_next;
            sum1_reg  <= sum_next;
            div1_reg  <= div_next;
            gm1_reg   <= gray_max[SB-1:0];
            mx1_reg   <= mx_in;
            for (int o = 0; o < 3; o++)
            begin
                pass1_reg[o] <= pass_next[o];
                for (int i = 0; i < 3; i++)
                    prod1_reg[o][i] <= PROD_W'(SEPIA_WEIGHT[o][i]) * PROD_W'(samp[i]);
            end
        end
        if (rdy2)
        begin
            ctrl2_reg <= ctrl1_reg;
            div2_reg  <= div1_reg;
            gm2_reg   <= gm1_reg;
            mx2_reg   <= mx1_reg;
            num2_reg  <= NUM_W'(sum1_reg) * NUM_W'(gm1_reg);
            for (int o = 0; o < 3; o++)
            begin
                pass2_reg[o] <= pass1_reg[o];
                sep2_reg[o]  <= SEP_W'(prod1_reg[o][0]) + SEP_W'(prod1_reg[o][1])
                              + SEP_W'(prod1_reg[o][2]);
            end
        end
        if (rdy3)
        begin
            ctrl3_reg <= ctrl2_reg;
            div3_reg  <= div2_reg;
            gm3_reg   <= gm2_reg;
            mx3_reg   <= mx2_reg;
            num3_reg  <= num2_reg;
            for (int o = 0; o < 3; o++)
            begin
                pass3_reg[o] <= pass2_reg[o];
                mul3_reg[o]  <= MUL_W'(sep2_reg[o]) * MUL_W'(RECIP);
            end
        end
        if (rdy4)
        begin
            ctrl4_reg <= ctrl3_reg;
            div4_reg  <= div3_reg;
            gm4_reg   <= gm3_reg;
            num4_reg  <= num3_reg;
            for (int o = 0; o < 3; o++)
                rgb4_reg[o] <= rgb4_next[o];
        end
    end

    assign out_valid = v4_reg;
    assign ctrl      = ctrl4_reg;
    assign red       = rgb4_reg[0];
    assign green     = rgb4_reg[1];
    assign blue      = rgb4_reg[2];
    assign gm        = gm4_reg;
    assign divisor   = div4_reg;
    assign num       = num4_reg;

endmodule

@@ design/rpct_div_stage.sv @@
// One restoring division step of the gray level quotient, as a pipeline stage.
module rpct_div_stage
    import rpct_pkg::*;
#(
    parameter int SB   = SAMPLE_BITS_DEF,
    parameter int STEP = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rpct_ctrl_t      ctrl_in,
    input  logic [SB-1:0]   red_in,
    input  logic [SB-1:0]   green_in,
    input  logic [SB-1:0]   blue_in,
    input  logic [SB-1:0]   gm_in,
    input  logic [SB+1:0]   div_in,
    input  logic [2*SB+1:0] rem_in,
    input  logic [SB-1:0]   quo_in,
    output logic            out_valid,
    input  logic            out_ready,
    output rpct_ctrl_t      ctrl_out,
    output logic [SB-1:0]   red_out,
    output logic [SB-1:0]   green_out,
    output logic [SB-1:0]   blue_out,
    output logic [SB-1:0]   gm_out,
    output logic [SB+1:0]   div_out,
    output logic [2*SB+1:0] rem_out,
    output logic [SB-1:0]   quo_out
);

    localparam int REM_W = 2 * SB + 2;

    logic             valid_reg;
    rpct_ctrl_t       ctrl_reg;
    logic [SB-1:0]    red_reg, green_reg, blue_reg, gm_reg, quo_reg;
    logic [SB+1:0]    div_reg;
    logic [REM_W-1:0] rem_reg;

    logic [REM_W-1:0] shifted;
    logic             take;
    logic [REM_W-1:0] rem_next;
    logic [SB-1:0]    quo_next;

    assign in_ready = !valid_reg || out_ready;

    // The quotient stays below 2**SB when the sum is under the divisor; other
    // words are flagged as saturated and their quotient is ignored.
    always_comb
    begin
        shifted  = REM_W'(div_in) << STEP;
        take     = rem_in >= shifted;
        rem_next = take ? (rem_in - shifted) : rem_in;
        quo_next = quo_in;
        quo_next[STEP] = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            ctrl_reg  <= ctrl_in;
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
            gm_reg    <= gm_in;
            div_reg   <= div_in;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign ctrl_out  = ctrl_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign gm_out    = gm_reg;
    assign div_out   = div_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

endmodule

@@ design/rpct_out_stage.sv @@
// Output register: final field selection by mode and packing of the result word.
module rpct_out_stage
    import rpct_pkg::*;
#(
    parameter int SB = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rpct_ctrl_t            ctrl,
    input  logic [SB-1:0]         red,
    input  logic [SB-1:0]         green,
    input  logic [SB-1:0]         blue,
    input  logic [SB-1:0]         gm,
    input  logic [SB-1:0]         quo,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_DATA_W-1:0] m_data
);

    logic                  valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;
    logic [SB-1:0]         gray;
    logic                  black;
    logic [OUT_DATA_W-1:0] data_next;

    assign in_ready = !valid_reg || m_ready;

    always_comb
    begin
        gray  = '0;
        black = 1'b0;
        if (ctrl.mode == MODE_GRAY)
            gray = ctrl.gray_sat ? gm : quo;
        if (ctrl.mode == MODE_BITMAP)
            black = ctrl.black;
        data_next = {7'd0, black, FIELD_W'(gray), FIELD_W'(blue), FIELD_W'(green),
                     FIELD_W'(red)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

@@ design/rgb_pixel_color_transform_core.sv @@
// Throughput: one word per cycle unless m_axis_tready holds the pipeline; four front
// stages, one gray-level division step per stage over SAMPLE_BITS stages, and one
// output register.
// Each stage holds its word under back-pressure, so a stall loses and repeats nothing.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register defaults:
// bitmap mode, input and gray maximum 255, red channel selected.
module rgb_pixel_color_transform_core
    import rpct_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: red_in[15:0], green_in[31:16], blue_in[47:32].
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: red_out[15:0], green_out[31:16], blue_out[47:32],
    // gray_level[63:48], black_bit[64], zero padding[71:65].
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int REM_W = 2 * SB + 2;

    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] in_max;
    logic [FIELD_W-1:0] gray_max;
    logic [CHSEL_W-1:0] chsel;

    rpct_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .in_max    (in_max),
        .gray_max  (gray_max),
        .chsel     (chsel)
    );

    // Division chain links; entry 0 is the front output.
    logic             p_valid [SB+1];
    logic             p_ready [SB+1];
    rpct_ctrl_t       p_ctrl  [SB+1];
    logic [SB-1:0]    p_red   [SB+1];
    logic [SB-1:0]    p_green [SB+1];
    logic [SB-1:0]    p_blue  [SB+1];
    logic [SB-1:0]    p_gm    [SB+1];
    logic [SB+1:0]    p_div   [SB+1];
    logic [REM_W-1:0] p_rem   [SB+1];
    logic [SB-1:0]    p_quo   [SB+1];

    rpct_front #(.SB(SB)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red_in    (s_axis_tdata[15:0]),
        .green_in  (s_axis_tdata[31:16]),
        .blue_in   (s_axis_tdata[47:32]),
        .mode      (mode),
        .in_max    (in_max),
        .gray_max  (gray_max),
        .chsel     (chsel),
        .out_valid (p_valid[0]),
        .out_ready (p_ready[0]),
        .ctrl      (p_ctrl[0]),
        .red       (p_red[0]),
        .green     (p_green[0]),
        .blue      (p_blue[0]),
        .gm        (p_gm[0]),
        .divisor   (p_div[0]),
        .num       (p_rem[0])
    );

    assign p_quo[0] = '0;

    for (genvar j = 0; j < SB; j++)
    begin : g_div
        rpct_div_stage #(.SB(SB), .STEP(SB - 1 - j)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (p_valid[j]),
            .in_ready  (p_ready[j]),
            .ctrl_in   (p_ctrl[j]),
            .red_in    (p_red[j]),
            .green_in  (p_green[j]),
            .blue_in   (p_blue[j]),
            .gm_in     (p_gm[j]),
            .div_in    (p_div[j]),
            .rem_in    (p_rem[j]),
            .quo_in    (p_quo[j]),
            .out_valid (p_valid[j+1]),
            .out_ready (p_ready[j+1]),
            .ctrl_out  (p_ctrl[j+1]),
            .red_out   (p_red[j+1]),
            .green_out (p_green[j+1]),
            .blue_out  (p_blue[j+1]),
            .gm_out    (p_gm[j+1]),
            .div_out   (p_div[j+1]),
            .rem_out   (p_rem[j+1]),
            .quo_out   (p_quo[j+1])
        );
    end

    rpct_out_stage #(.SB(SB)) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (p_valid[SB]),
        .in_ready (p_ready[SB]),
        .ctrl     (p_ctrl[SB]),
        .red      (p_red[SB]),
        .green    (p_green[SB]),
        .blue     (p_blue[SB]),
        .gm       (p_gm[SB]),
        .quo      (p_quo[SB]),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata)
    );

endmodule
